@@ hw/rtl/hex_patch_text_to_segment_writes_defines.svh @@
// ----------------------------------------------------------------------------
// Patch converter assertion macros
// Assertion macros shared by the patch converter modules.
// ----------------------------------------------------------------------------
`ifndef HEX_PATCH_TEXT_TO_SEGMENT_WRITES_DEFINES_SVH
`define HEX_PATCH_TEXT_TO_SEGMENT_WRITES_DEFINES_SVH
// Implication that must hold at every clock edge outside reset.
`define HP_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("check failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define HP_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("check failed");
`endif

@@ hw/rtl/hptsw_pkg.sv @@
// ----------------------------------------------------------------------------
// Patch converter package
// Types and constants shared by the front parser and the segment mapper.
// ----------------------------------------------------------------------------
`default_nettype none
package hptsw_pkg;
  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_CHAR   = 2'd2;

  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3b;

  typedef enum logic [2:0] {
    PH_LINE, PH_SKIP, PH_OFS, PH_FIELD2, PH_DATA, PH_PAIR
  } phase_t;

  typedef enum logic [1:0] {CMD_CLEAR, CMD_APPEND, CMD_WRITE} cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] a;
    logic [31:0] b;
  } cmd_t;

  typedef enum logic [1:0] {MS_IDLE, MS_READ, MS_CHECK} map_state_t;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction
endpackage
`default_nettype wire

@@ hw/rtl/hptsw_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module hptsw_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hw/rtl/hptsw_front.sv @@
// ----------------------------------------------------------------------------
// Patch text front end
// Accepts items, parses patch text and issues table and write commands.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hex_patch_text_to_segment_writes_defines.svh"
module hptsw_front
  import hptsw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  func,
  input  wire logic [31:0] seg_base,
  input  wire logic [31:0] seg_length,
  input  wire logic [7:0]  text_char,
  input  wire logic        text_last,
  output logic             cmd_valid,
  input  wire logic        cmd_ready,
  output cmd_t             cmd
);
  phase_t      phase, phase_next;
  logic [31:0] offset, offset_next;
  logic [3:0]  digits, digits_next;
  logic [4:0]  high_nibble, high_nibble_next;
  logic        emit;
  logic [7:0]  wbyte;
  logic [4:0]  h;
  logic        acc;

  assign in_ready = !cmd_valid || cmd_ready;
  assign acc = in_valid && in_ready;
  assign h = hex_val(text_char);

  always_comb begin
    phase_next = phase;
    offset_next = offset;
    digits_next = digits;
    high_nibble_next = high_nibble;
    emit = 1'b0;
    wbyte = 8'd0;
    case (phase)
      PH_LINE, PH_OFS: begin
        if (phase == PH_LINE && text_char == CH_LF) begin
          phase_next = PH_LINE;
        end else if (phase == PH_LINE && (text_char == CH_HASH || text_char == CH_SEMI ||
                     text_char == CH_CR || text_char == CH_SPACE ||
                     text_char == CH_NUL)) begin
          phase_next = PH_SKIP;
        end else begin
          if (phase == PH_LINE) begin
            offset_next = 32'd0;
            digits_next = 4'd0;
          end
          phase_next = PH_OFS;
          if (text_char == CH_LF) begin
            phase_next = PH_LINE;
            offset_next = 32'd0;
            digits_next = 4'd0;
            high_nibble_next = 5'd0;
          end else if (text_char == CH_SPACE) begin
            phase_next = PH_FIELD2;
          end else if (h[4] && digits_next < 4'd8) begin
            offset_next = {offset_next[27:0], h[3:0]};
            digits_next = digits_next + 4'd1;
          end else begin
            digits_next = 4'd8;
          end
        end
      end
      PH_FIELD2: begin
        if (text_char == CH_LF) begin
          phase_next = PH_LINE;
          offset_next = 32'd0;
          digits_next = 4'd0;
          high_nibble_next = 5'd0;
        end else if (text_char == CH_SPACE) begin
          phase_next = PH_DATA;
        end
      end
      PH_DATA, PH_PAIR: begin
        if (text_char == CH_LF) begin
          phase_next = PH_LINE;
          offset_next = 32'd0;
          digits_next = 4'd0;
          high_nibble_next = 5'd0;
        end else if (text_char == CH_CR || text_char == CH_NUL) begin
          high_nibble_next = 5'd0;
          phase_next = PH_SKIP;
        end else if (phase == PH_DATA) begin
          high_nibble_next = h;
          phase_next = PH_PAIR;
        end else begin
          if (high_nibble[4]) begin
            wbyte = h[4] ? {high_nibble[3:0], h[3:0]} : {4'd0, high_nibble[3:0]};
          end
          emit = 1'b1;
          offset_next = offset + 32'd1;
          high_nibble_next = 5'd0;
          phase_next = PH_DATA;
        end
      end
      default: begin
        if (text_char == CH_LF) begin
          phase_next = PH_LINE;
          offset_next = 32'd0;
          digits_next = 4'd0;
          high_nibble_next = 5'd0;
        end else begin
          phase_next = PH_SKIP;
        end
      end
    endcase
    if (text_last) begin
      phase_next = PH_LINE;
      offset_next = 32'd0;
      digits_next = 4'd0;
      high_nibble_next = 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LINE;
      offset <= 32'd0;
      digits <= 4'd0;
      high_nibble <= 5'd0;
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        cmd_valid <= 1'b0;
      end
      if (acc) begin
        case (func)
          FUNC_CLEAR: begin
            cmd_valid <= 1'b1;
            cmd.kind <= CMD_CLEAR;
          end
          FUNC_APPEND: begin
            cmd_valid <= 1'b1;
            cmd.kind <= CMD_APPEND;
            cmd.a <= seg_base;
            cmd.b <= seg_length;
          end
          FUNC_CHAR: begin
            phase <= phase_next;
            offset <= offset_next;
            digits <= digits_next;
            high_nibble <= high_nibble_next;
            if (emit) begin
              cmd_valid <= 1'b1;
              cmd.kind <= CMD_WRITE;
              cmd.a <= offset;
              cmd.b <= {24'd0, wbyte};
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  `HP_ASSERT_NEXT(a_hold, clk, rst, cmd_valid && !cmd_ready, cmd_valid && $stable(cmd))
  `HP_ASSERT_IMP(a_digits, clk, rst, 1'b1, digits <= 4'd8)
  `HP_ASSERT_IMP(a_nib, clk, rst, phase != PH_PAIR && phase != PH_DATA, high_nibble == 5'd0)
endmodule
`default_nettype wire

@@ hw/rtl/hptsw_back.sv @@
// ----------------------------------------------------------------------------
// Segment mapper
// Holds the segment table and walks it to place each patch byte.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hex_patch_text_to_segment_writes_defines.svh"
module hptsw_back
  import hptsw_pkg::*;
#(
  parameter int MaxSegments = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  output logic             cmd_ready,
  input  wire cmd_t        cmd,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      write_address,
  output logic [7:0]       write_byte
);
  localparam int Aw = (MaxSegments > 1) ? $clog2(MaxSegments) : 1;
  localparam int Cw = $clog2(MaxSegments + 1);

  map_state_t  state, state_next;
  logic [Cw-1:0] count;
  logic [Aw-1:0] idx;
  logic [31:0] rel;
  logic [7:0]  val;
  logic [31:0] base_q, len_q;
  logic        we;
  logic        last;
  logic        hit;
  logic        load;

  assign we = (state == MS_IDLE) && cmd_valid && cmd.kind == CMD_APPEND &&
              count < Cw'(MaxSegments);

  hptsw_ram #(.Width(32), .Depth(1 << Aw)) u_base (
    .clk(clk), .we(we), .waddr(count[Aw-1:0]), .wdata(cmd.a),
    .raddr(idx), .rdata(base_q));
  hptsw_ram #(.Width(32), .Depth(1 << Aw)) u_len (
    .clk(clk), .we(we), .waddr(count[Aw-1:0]), .wdata(cmd.b),
    .raddr(idx), .rdata(len_q));

  assign last = (Cw'(idx) + Cw'(1)) >= count;
  assign hit = rel < len_q;
  assign load = (state == MS_CHECK) && hit && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      MS_IDLE: begin
        if (cmd_valid && cmd.kind == CMD_WRITE && count != '0) state_next = MS_READ;
      end
      MS_READ: state_next = MS_CHECK;
      MS_CHECK: begin
        if (hit) begin
          if (load) state_next = MS_IDLE;
        end else if (last) state_next = MS_IDLE;
        else state_next = MS_READ;
      end
      default: state_next = MS_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = (state == MS_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MS_IDLE;
      count <= '0;
      idx <= '0;
    end else begin
      state <= state_next;
      case (state)
        MS_IDLE: begin
          idx <= '0;
          if (cmd_valid) begin
            case (cmd.kind)
              CMD_CLEAR: count <= '0;
              CMD_APPEND: if (we) count <= count + Cw'(1);
              default: begin
              end
            endcase
          end
        end
        MS_CHECK: begin
          if (hit) begin
            if (load) begin
              write_address <= base_q + rel;
              write_byte <= val;
            end
          end else if (!last) begin
            rel <= rel - len_q;
            idx <= idx + Aw'(1);
          end
        end
        default: begin
        end
      endcase
    end
    if (state == MS_IDLE && cmd_valid) begin
      rel <= cmd.a;
      val <= cmd.b[7:0];
    end
  end

  `HP_ASSERT_IMP(a_count, clk, rst, 1'b1, count <= Cw'(MaxSegments))
  `HP_ASSERT_NEXT(a_out, clk, rst, out_valid && !out_ready,
                  out_valid && $stable(write_address))
  `HP_ASSERT_IMP(a_idx, clk, rst, state == MS_CHECK, Cw'(idx) < count)
endmodule
`default_nettype wire

@@ hw/rtl/hex_patch_text_to_segment_writes.sv @@
// Path: command register, a read and a check per segment walked, output register.
// Throughput: one item per cycle for non-writing items unless a command waits on a
// busy mapper; a patch byte holds the mapper through its one-port table walk.
// Reset (rst, synchronous) empties the table and returns the parser to line start.
// ----------------------------------------------------------------------------
// Patch text to segment writes
// Parses patch text and maps each patch byte through the segment table.
// ----------------------------------------------------------------------------
`default_nettype none
module hex_patch_text_to_segment_writes
  import hptsw_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // seg_base[31:0], seg_length[63:32], text_char[71:64]
  input  wire logic [71:0] s_axis_tdata,
  // func
  input  wire logic [1:0]  s_axis_tuser,
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // write_address[31:0], write_byte[39:32]
  output logic [39:0]      m_axis_tdata
);
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic [31:0] write_address;
  logic [7:0]  write_byte;

  hptsw_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .func(s_axis_tuser), .seg_base(s_axis_tdata[31:0]),
    .seg_length(s_axis_tdata[63:32]), .text_char(s_axis_tdata[71:64]),
    .text_last(s_axis_tlast),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd));

  hptsw_back #(.MaxSegments(MAX_SEGMENTS)) u_back (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .write_address(write_address), .write_byte(write_byte));

  assign m_axis_tdata = {write_byte, write_address};
endmodule
`default_nettype wire
